### rtl/aopu_pkg.sv
// ----------------------------------------------------------------------------
// aopu_pkg
// Shared types, constants and tables of the arc odometry pose update block.
// ----------------------------------------------------------------------------
package aopu_pkg;

    localparam int LANES        = 2;
    localparam int TRIG_BITS    = 30;
    localparam int CORDIC_STEPS = 30;

    localparam logic signed [63:0] RAD_TO_BAM  = 64'sd683565276;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [47:0] POS_MAX     = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] POS_MIN     = 48'sh8000_0000_0000;
    localparam logic signed [31:0] DELTA_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] DELTA_MIN   = 32'sh8000_0000;
    localparam logic signed [63:0] CHORD_ONE   = 64'sd1 <<< TRIG_BITS;

    typedef enum logic [2:0] {
        CFG_GYRO_COUNT     = 3'd0,
        CFG_HORIZ_COUNT    = 3'd1,
        CFG_VERT_COUNT     = 3'd2,
        CFG_HORIZ_OFFSET_A = 3'd3,
        CFG_HORIZ_OFFSET_B = 3'd4,
        CFG_VERT_OFFSET_A  = 3'd5,
        CFG_VERT_OFFSET_B  = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK            = 2'd0,
        STATUS_NO_SOURCE     = 2'd1,
        STATUS_EQUAL_OFFSETS = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SELECT,
        ST_HEAD_MUL,
        ST_HEAD_DIV,
        ST_HALF,
        ST_SIN_H,
        ST_CHORD_MUL,
        ST_CHORD_DIV,
        ST_WH_D,
        ST_WH_O,
        ST_WV_D,
        ST_WV_O,
        ST_MERGE,
        ST_SIN_M,
        ST_ROT_A,
        ST_ROT_B,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic signed [31:0] gyro_delta_a;
        logic signed [31:0] gyro_delta_b;
        logic signed [31:0] horiz_dist_a;
        logic signed [31:0] horiz_dist_b;
        logic signed [31:0] vert_dist_a;
        logic signed [31:0] vert_dist_b;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] position_x;
        logic signed [47:0] position_y;
        logic [31:0]        heading_angle;
        logic [1:0]         status_code;
        logic               no_vertical;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic rnd;
    } lane_cmd_t;

    // atan(2^-i) in binary angle units
    function automatic logic [29:0] atan_bam(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051E;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2F;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2FA;
            5'd15: v = 30'h0000517D;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A30;
            5'd19: v = 30'h00000518;
            5'd20: v = 30'h0000028C;
            5'd21: v = 30'h00000146;
            5'd22: v = 30'h000000A3;
            5'd23: v = 30'h00000051;
            5'd24: v = 30'h00000029;
            5'd25: v = 30'h00000014;
            5'd26: v = 30'h0000000A;
            5'd27: v = 30'h00000005;
            5'd28: v = 30'h00000003;
            5'd29: v = 30'h00000001;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

### rtl/arc_odometry_pose_update.sv
// ----------------------------------------------------------------------------
// arc_odometry_pose_update
// Tracking-wheel and gyro odometry: keeps x, y and heading, one update per
// item, with two multiply lanes working on wheel a and wheel b side by side.
// ----------------------------------------------------------------------------
// Input items (s_valid/s_ready) carry gyro and wheel distance deltas; one
// result item (m_valid/m_ready) per input item gives the pose after it.
// Configuration is to be written through cfg_we/cfg_index/cfg_wdata only
// while idle; the user is bound to this, the block does not enforce it.
// One item is worked on at a time; s_ready is high only when idle, and it
// returns high in the same cycle that a new result appears on m_data.
// With no heading source or equal offsets the item goes straight to its
// result; a zero half turn skips the half-angle sine and the chord division.
// The 64-step divider serves the wheel heading and the chord factor, the
// 30-step CORDIC gives the half-angle sine and the mid-angle sine and cosine,
// and the two lanes form their products in pairs.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and its result waits until that register is free.
// Reset clears the pose to zero, counts to 0/0/2 and offsets to zero.
// ----------------------------------------------------------------------------
module arc_odometry_pose_update (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  aopu_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output aopu_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_wdata
);

    // configuration
    logic [1:0]         gyro_count_reg;
    logic [1:0]         horiz_count_reg;
    logic [1:0]         vert_count_reg;
    logic signed [31:0] horiz_offset_a_reg;
    logic signed [31:0] horiz_offset_b_reg;
    logic signed [31:0] vert_offset_a_reg;
    logic signed [31:0] vert_offset_b_reg;

    // control
    aopu_pkg::seq_state_t state_reg, state_next;
    logic                 issued_reg, issued_next;
    aopu_pkg::status_t    status_reg, status_next;
    logic                 m_valid_reg, m_valid_next;

    // pose
    logic signed [47:0] pose_x_reg, pose_x_next;
    logic signed [47:0] pose_y_reg, pose_y_next;
    logic [31:0]        heading_reg, heading_next;

    // payload
    aopu_pkg::in_item_t  in_reg;
    aopu_pkg::out_item_t m_data_reg, m_data_next;
    logic signed [31:0]  delta_reg, delta_next;
    logic signed [31:0]  half_reg, half_next;
    logic [31:0]         mid_reg, mid_next;
    logic signed [63:0]  prod_reg, prod_next;
    logic signed [33:0]  sin_h_reg, sin_h_next;
    logic signed [63:0]  chord_reg, chord_next;
    logic signed [63:0]  lx_reg, lx_next;
    logic signed [63:0]  ly_reg, ly_next;
    logic signed [33:0]  sin_m_reg, sin_m_next;
    logic signed [33:0]  cos_m_reg, cos_m_next;
    logic signed [63:0]  term_reg [aopu_pkg::LANES];
    logic signed [63:0]  term_next [aopu_pkg::LANES];
    logic signed [63:0]  hsum_reg [aopu_pkg::LANES];
    logic signed [63:0]  hsum_next [aopu_pkg::LANES];
    logic signed [63:0]  vsum_reg [aopu_pkg::LANES];
    logic signed [63:0]  vsum_next [aopu_pkg::LANES];

    // units
    aopu_pkg::lane_cmd_t lane_cmd;
    logic signed [63:0]  lane_a [aopu_pkg::LANES];
    logic signed [63:0]  lane_b [aopu_pkg::LANES];
    logic signed [63:0]  lane_res [aopu_pkg::LANES];
    logic                lane_done [aopu_pkg::LANES];
    logic                div_start;
    logic signed [63:0]  div_num;
    logic signed [63:0]  div_den;
    logic                div_done;
    logic signed [63:0]  div_quo;
    logic                cordic_start;
    logic [31:0]         cordic_angle;
    logic                cordic_done;
    logic signed [33:0]  cordic_sin;
    logic signed [33:0]  cordic_cos;

    // decoded item values
    logic [1:0]         ng, nh, nv;
    logic               use_h;
    logic signed [32:0] num33;
    logic signed [32:0] den33;
    logic signed [32:0] gyro_sum;
    logic signed [31:0] gyro_avg;
    logic signed [31:0] half_val;
    logic signed [63:0] sin_h64;
    logic signed [63:0] two_sh;
    logic signed [63:0] wheel_hd [aopu_pkg::LANES];
    logic signed [63:0] wheel_ho [aopu_pkg::LANES];
    logic signed [63:0] wheel_vd [aopu_pkg::LANES];
    logic signed [63:0] wheel_vo [aopu_pkg::LANES];
    logic signed [63:0] pose_x_sum;
    logic signed [63:0] pose_y_sum;

    function automatic logic [1:0] clamp_count(input logic [1:0] v);
        return (v == 2'd3) ? 2'd2 : v;
    endfunction

    // truncating average over 0, 1 or 2 lanes
    function automatic logic signed [63:0] lane_avg(input logic [1:0] n,
                                                    input logic signed [63:0] s0,
                                                    input logic signed [63:0] s1);
        logic signed [63:0] s;
        s = s0 + s1;
        if (n == 2'd0) begin
            return '0;
        end else if (n == 2'd1) begin
            return s0;
        end
        return (s + $signed({63'd0, s[63]})) >>> 1;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        if (v[63:47] == {17{v[47]}}) begin
            return v[47:0];
        end
        return v[63] ? aopu_pkg::POS_MIN : aopu_pkg::POS_MAX;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v[63:31] == {33{v[31]}}) begin
            return v[31:0];
        end
        return v[63] ? aopu_pkg::DELTA_MIN : aopu_pkg::DELTA_MAX;
    endfunction

    // ---------------------------------------------------------------- lanes
    for (genvar g = 0; g < aopu_pkg::LANES; g++) begin : g_lane
        aopu_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (lane_cmd),
            .op_a    (lane_a[g]),
            .op_b    (lane_b[g]),
            .done    (lane_done[g]),
            .result  (lane_res[g])
        );
    end

    aopu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    aopu_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .angle   (cordic_angle),
        .done    (cordic_done),
        .sin_out (cordic_sin),
        .cos_out (cordic_cos)
    );

    // ------------------------------------------------------------ decoding
    always_comb begin
        ng    = clamp_count(gyro_count_reg);
        nh    = clamp_count(horiz_count_reg);
        nv    = clamp_count(vert_count_reg);
        use_h = (nh == 2'd2);
        if (use_h) begin
            num33 = 33'(in_reg.horiz_dist_a) - 33'(in_reg.horiz_dist_b);
            den33 = 33'(horiz_offset_a_reg) - 33'(horiz_offset_b_reg);
        end else begin
            num33 = 33'(in_reg.vert_dist_a) - 33'(in_reg.vert_dist_b);
            den33 = 33'(vert_offset_a_reg) - 33'(vert_offset_b_reg);
        end
        gyro_sum = 33'(in_reg.gyro_delta_a) + 33'(in_reg.gyro_delta_b);
        if (ng == 2'd2) begin
            gyro_avg = 32'((gyro_sum + $signed({32'd0, gyro_sum[32]})) >>> 1);
        end else begin
            gyro_avg = in_reg.gyro_delta_a;
        end
        half_val = (delta_reg + $signed({31'd0, delta_reg[31]})) >>> 1;
        sin_h64  = 64'(sin_h_reg);
        two_sh   = sin_h64 <<< 1;
        wheel_hd[0] = 64'(in_reg.horiz_dist_a);
        wheel_hd[1] = 64'(in_reg.horiz_dist_b);
        wheel_ho[0] = 64'(horiz_offset_a_reg);
        wheel_ho[1] = 64'(horiz_offset_b_reg);
        wheel_vd[0] = 64'(in_reg.vert_dist_a);
        wheel_vd[1] = 64'(in_reg.vert_dist_b);
        wheel_vo[0] = 64'(vert_offset_a_reg);
        wheel_vo[1] = 64'(vert_offset_b_reg);
        pose_x_sum = 64'(pose_x_reg) + lane_res[0] - lane_res[1];
        pose_y_sum = 64'(pose_y_reg) + lane_res[0] + lane_res[1];
    end

    // ------------------------------------------------------- unit operands
    always_comb begin
        lane_cmd.start = 1'b0;
        lane_cmd.rnd   = 1'b1;
        div_start      = 1'b0;
        div_num        = prod_reg;
        div_den        = 64'(den33);
        cordic_start   = 1'b0;
        cordic_angle   = mid_reg;
        for (int k = 0; k < aopu_pkg::LANES; k++) begin
            lane_a[k] = '0;
            lane_b[k] = '0;
        end
        unique case (state_reg)
            aopu_pkg::ST_HEAD_MUL: begin
                lane_cmd.start = !issued_reg;
                lane_cmd.rnd   = 1'b0;
                lane_a[0]      = 64'(num33);
                lane_b[0]      = aopu_pkg::RAD_TO_BAM;
            end
            aopu_pkg::ST_CHORD_MUL: begin
                lane_cmd.start = !issued_reg;
                lane_cmd.rnd   = 1'b0;
                lane_a[0]      = sin_h64;
                lane_b[0]      = aopu_pkg::RAD_TO_BAM;
            end
            aopu_pkg::ST_HEAD_DIV: begin
                div_start = !issued_reg;
            end
            aopu_pkg::ST_CHORD_DIV: begin
                div_start = !issued_reg;
                div_den   = 64'(half_reg);
            end
            aopu_pkg::ST_SIN_H: begin
                cordic_start = !issued_reg;
                cordic_angle = half_reg;
            end
            aopu_pkg::ST_SIN_M: begin
                cordic_start = !issued_reg;
            end
            aopu_pkg::ST_WH_D: begin
                lane_cmd.start = !issued_reg;
                for (int k = 0; k < aopu_pkg::LANES; k++) begin
                    lane_a[k] = wheel_hd[k];
                    lane_b[k] = chord_reg;
                end
            end
            aopu_pkg::ST_WH_O: begin
                lane_cmd.start = !issued_reg;
                for (int k = 0; k < aopu_pkg::LANES; k++) begin
                    lane_a[k] = wheel_ho[k];
                    lane_b[k] = two_sh;
                end
            end
            aopu_pkg::ST_WV_D: begin
                lane_cmd.start = !issued_reg;
                for (int k = 0; k < aopu_pkg::LANES; k++) begin
                    lane_a[k] = wheel_vd[k];
                    lane_b[k] = chord_reg;
                end
            end
            aopu_pkg::ST_WV_O: begin
                lane_cmd.start = !issued_reg;
                for (int k = 0; k < aopu_pkg::LANES; k++) begin
                    lane_a[k] = wheel_vo[k];
                    lane_b[k] = two_sh;
                end
            end
            aopu_pkg::ST_ROT_A: begin
                lane_cmd.start = !issued_reg;
                lane_a[0]      = lx_reg;
                lane_b[0]      = 64'(cos_m_reg);
                lane_a[1]      = ly_reg;
                lane_b[1]      = 64'(sin_m_reg);
            end
            aopu_pkg::ST_ROT_B: begin
                lane_cmd.start = !issued_reg;
                lane_a[0]      = lx_reg;
                lane_b[0]      = 64'(sin_m_reg);
                lane_a[1]      = ly_reg;
                lane_b[1]      = 64'(cos_m_reg);
            end
            default: ;
        endcase
    end

    // ----------------------------------------------------------- sequencer
    always_comb begin
        state_next   = state_reg;
        issued_next  = issued_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        pose_x_next  = pose_x_reg;
        pose_y_next  = pose_y_reg;
        heading_next = heading_reg;
        delta_next   = delta_reg;
        half_next    = half_reg;
        mid_next     = mid_reg;
        prod_next    = prod_reg;
        sin_h_next   = sin_h_reg;
        chord_next   = chord_reg;
        lx_next      = lx_reg;
        ly_next      = ly_reg;
        sin_m_next   = sin_m_reg;
        cos_m_next   = cos_m_reg;
        term_next    = term_reg;
        hsum_next    = hsum_reg;
        vsum_next    = vsum_reg;

        if (lane_cmd.start || div_start || cordic_start) begin
            issued_next = 1'b1;
        end

        unique case (state_reg)
            aopu_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = aopu_pkg::ST_SELECT;
                end
            end
            aopu_pkg::ST_SELECT: begin
                status_next = aopu_pkg::STATUS_OK;
                if (ng != 2'd0) begin
                    delta_next = gyro_avg;
                    state_next = aopu_pkg::ST_HALF;
                end else if (nh == 2'd2 || nv == 2'd2) begin
                    if (den33 == '0) begin
                        status_next = aopu_pkg::STATUS_EQUAL_OFFSETS;
                        state_next  = aopu_pkg::ST_DONE;
                    end else begin
                        state_next = aopu_pkg::ST_HEAD_MUL;
                    end
                end else begin
                    status_next = aopu_pkg::STATUS_NO_SOURCE;
                    state_next  = aopu_pkg::ST_DONE;
                end
            end
            aopu_pkg::ST_HEAD_MUL: begin
                if (issued_reg && lane_done[0]) begin
                    issued_next = 1'b0;
                    prod_next   = lane_res[0];
                    state_next  = aopu_pkg::ST_HEAD_DIV;
                end
            end
            aopu_pkg::ST_HEAD_DIV: begin
                if (issued_reg && div_done) begin
                    issued_next = 1'b0;
                    delta_next  = sat32(div_quo);
                    state_next  = aopu_pkg::ST_HALF;
                end
            end
            aopu_pkg::ST_HALF: begin
                half_next = half_val;
                mid_next  = heading_reg + half_val;
                if (half_val == '0) begin
                    sin_h_next = '0;
                    chord_next = aopu_pkg::CHORD_ONE;
                    state_next = aopu_pkg::ST_WH_D;
                end else begin
                    state_next = aopu_pkg::ST_SIN_H;
                end
            end
            aopu_pkg::ST_SIN_H: begin
                if (issued_reg && cordic_done) begin
                    issued_next = 1'b0;
                    sin_h_next  = cordic_sin;
                    state_next  = aopu_pkg::ST_CHORD_MUL;
                end
            end
            aopu_pkg::ST_CHORD_MUL: begin
                if (issued_reg && lane_done[0]) begin
                    issued_next = 1'b0;
                    prod_next   = lane_res[0];
                    state_next  = aopu_pkg::ST_CHORD_DIV;
                end
            end
            aopu_pkg::ST_CHORD_DIV: begin
                if (issued_reg && div_done) begin
                    issued_next = 1'b0;
                    chord_next  = div_quo;
                    state_next  = aopu_pkg::ST_WH_D;
                end
            end
            aopu_pkg::ST_WH_D: begin
                if (issued_reg && lane_done[0]) begin
                    issued_next = 1'b0;
                    term_next   = lane_res;
                    state_next  = aopu_pkg::ST_WH_O;
                end
            end
            aopu_pkg::ST_WH_O: begin
                if (issued_reg && lane_done[0]) begin
                    issued_next = 1'b0;
                    for (int k = 0; k < aopu_pkg::LANES; k++) begin
                        hsum_next[k] = term_reg[k] + lane_res[k];
                    end
                    state_next = aopu_pkg::ST_WV_D;
                end
            end
            aopu_pkg::ST_WV_D: begin
                if (issued_reg && lane_done[0]) begin
                    issued_next = 1'b0;
                    term_next   = lane_res;
                    state_next  = aopu_pkg::ST_WV_O;
                end
            end
            aopu_pkg::ST_WV_O: begin
                if (issued_reg && lane_done[0]) begin
                    issued_next = 1'b0;
                    for (int k = 0; k < aopu_pkg::LANES; k++) begin
                        vsum_next[k] = term_reg[k] + lane_res[k];
                    end
                    state_next = aopu_pkg::ST_MERGE;
                end
            end
            aopu_pkg::ST_MERGE: begin
                lx_next    = lane_avg(nh, hsum_reg[0], hsum_reg[1]);
                ly_next    = lane_avg(nv, vsum_reg[0], vsum_reg[1]);
                state_next = aopu_pkg::ST_SIN_M;
            end
            aopu_pkg::ST_SIN_M: begin
                if (issued_reg && cordic_done) begin
                    issued_next = 1'b0;
                    sin_m_next  = cordic_sin;
                    cos_m_next  = cordic_cos;
                    state_next  = aopu_pkg::ST_ROT_A;
                end
            end
            aopu_pkg::ST_ROT_A: begin
                if (issued_reg && lane_done[0]) begin
                    issued_next = 1'b0;
                    pose_x_next = sat48(pose_x_sum);
                    state_next  = aopu_pkg::ST_ROT_B;
                end
            end
            aopu_pkg::ST_ROT_B: begin
                if (issued_reg && lane_done[0]) begin
                    issued_next  = 1'b0;
                    pose_y_next  = sat48(pose_y_sum);
                    heading_next = heading_reg + delta_reg;
                    state_next   = aopu_pkg::ST_DONE;
                end
            end
            aopu_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.position_x    = pose_x_reg;
                    m_data_next.position_y    = pose_y_reg;
                    m_data_next.heading_angle = heading_reg;
                    m_data_next.status_code   = status_reg;
                    m_data_next.no_vertical   = (vert_count_reg == 2'd0);
                    state_next                = aopu_pkg::ST_IDLE;
                end
            end
            default: state_next = aopu_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= aopu_pkg::ST_IDLE;
            issued_reg         <= 1'b0;
            status_reg         <= aopu_pkg::STATUS_OK;
            m_valid_reg        <= 1'b0;
            pose_x_reg         <= '0;
            pose_y_reg         <= '0;
            heading_reg        <= '0;
            gyro_count_reg     <= 2'd0;
            horiz_count_reg    <= 2'd0;
            vert_count_reg     <= 2'd2;
            horiz_offset_a_reg <= '0;
            horiz_offset_b_reg <= '0;
            vert_offset_a_reg  <= '0;
            vert_offset_b_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            issued_reg  <= issued_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
            pose_x_reg  <= pose_x_next;
            pose_y_reg  <= pose_y_next;
            heading_reg <= heading_next;
            if (cfg_we) begin
                case (aopu_pkg::cfg_index_t'(cfg_index))
                    aopu_pkg::CFG_GYRO_COUNT:     gyro_count_reg     <= cfg_wdata[1:0];
                    aopu_pkg::CFG_HORIZ_COUNT:    horiz_count_reg    <= cfg_wdata[1:0];
                    aopu_pkg::CFG_VERT_COUNT:     vert_count_reg     <= cfg_wdata[1:0];
                    aopu_pkg::CFG_HORIZ_OFFSET_A: horiz_offset_a_reg <= cfg_wdata;
                    aopu_pkg::CFG_HORIZ_OFFSET_B: horiz_offset_b_reg <= cfg_wdata;
                    aopu_pkg::CFG_VERT_OFFSET_A:  vert_offset_a_reg  <= cfg_wdata;
                    aopu_pkg::CFG_VERT_OFFSET_B:  vert_offset_b_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        m_data_reg <= m_data_next;
        delta_reg  <= delta_next;
        half_reg   <= half_next;
        mid_reg    <= mid_next;
        prod_reg   <= prod_next;
        sin_h_reg  <= sin_h_next;
        chord_reg  <= chord_next;
        lx_reg     <= lx_next;
        ly_reg     <= ly_next;
        sin_m_reg  <= sin_m_next;
        cos_m_reg  <= cos_m_next;
        term_reg   <= term_next;
        hsum_reg   <= hsum_next;
        vsum_reg   <= vsum_next;
    end

    assign s_ready = (state_reg == aopu_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ----------------------------------------------------------- assertions
    a_lanes_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_done[0] == lane_done[1])
        else $error("multiply lanes out of step");

    a_accept_to_select: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == aopu_pkg::ST_SELECT))
        else $error("accepted item not taken into work");

    a_pose_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == aopu_pkg::ST_DONE && status_reg != aopu_pkg::STATUS_OK)
        |-> ($stable(pose_x_reg) && $stable(pose_y_reg) && $stable(heading_reg)))
        else $error("pose moved without a heading source");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == aopu_pkg::ST_DONE))
        else $error("result item raised outside completion");

endmodule

### rtl/aopu_lane.sv
// ----------------------------------------------------------------------------
// aopu_lane
// One multiply lane: 64-bit signed product, modulo 2^64 on the magnitudes,
// optionally rounded by 2^30 with ties away from zero. Uses one 32x32
// multiplier over three partial products.
// ----------------------------------------------------------------------------
module aopu_lane (
    input  logic                aclk,
    input  logic                aresetn,
    input  aopu_pkg::lane_cmd_t cmd,
    input  logic signed [63:0]  op_a,
    input  logic signed [63:0]  op_b,
    output logic                done,
    output logic signed [63:0]  result
);

    localparam logic [2:0] STEP_LAST = 3'd5;

    logic [2:0]         step_reg;
    logic               done_reg;
    logic [63:0]        mag_a_reg;
    logic [63:0]        mag_b_reg;
    logic               neg_reg;
    logic               rnd_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        acc_reg;
    logic signed [63:0] result_reg;
    logic [31:0]        mul_x;
    logic [31:0]        mul_y;
    logic [63:0]        acc_rnd;
    logic [63:0]        mag_out;

    always_comb begin
        unique case (step_reg)
            3'd1: begin
                mul_x = mag_a_reg[31:0];
                mul_y = mag_b_reg[31:0];
            end
            3'd2: begin
                mul_x = mag_a_reg[31:0];
                mul_y = mag_b_reg[63:32];
            end
            default: begin
                mul_x = mag_a_reg[63:32];
                mul_y = mag_b_reg[31:0];
            end
        endcase
        acc_rnd = acc_reg + (64'd1 << (aopu_pkg::TRIG_BITS - 1));
        mag_out = rnd_reg ? (acc_rnd >> aopu_pkg::TRIG_BITS) : acc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (step_reg == STEP_LAST);
            if (cmd.start) begin
                step_reg <= 3'd1;
            end else if (step_reg == STEP_LAST) begin
                step_reg <= '0;
            end else if (step_reg != 3'd0) begin
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            mag_a_reg <= op_a[63] ? 64'(-op_a) : 64'(op_a);
            mag_b_reg <= op_b[63] ? 64'(-op_b) : 64'(op_b);
            neg_reg   <= op_a[63] ^ op_b[63];
            rnd_reg   <= cmd.rnd;
        end
        case (step_reg)
            3'd1: prod_reg <= 64'(mul_x) * 64'(mul_y);
            3'd2: begin
                acc_reg  <= prod_reg;
                prod_reg <= 64'(mul_x) * 64'(mul_y);
            end
            3'd3: begin
                acc_reg  <= acc_reg + {prod_reg[31:0], 32'h0};
                prod_reg <= 64'(mul_x) * 64'(mul_y);
            end
            3'd4: acc_reg <= acc_reg + {prod_reg[31:0], 32'h0};
            3'd5: result_reg <= neg_reg ? -$signed(mag_out) : $signed(mag_out);
            default: ;
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### rtl/aopu_div.sv
// ----------------------------------------------------------------------------
// aopu_div
// Signed 64-bit divider, quotient truncated toward zero. Restoring, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module aopu_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output logic               done,
    output logic signed [63:0] quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] quo_reg;
    logic [63:0] den_reg;
    logic [64:0] rem_reg;
    logic        neg_reg;
    logic [64:0] shifted;
    logic        fits;
    logic [64:0] rem_step;

    always_comb begin
        shifted  = {rem_reg[63:0], quo_reg[63]};
        fits     = (shifted >= {1'b0, den_reg});
        rem_step = fits ? (shifted - {1'b0, den_reg}) : shifted;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 6'd63);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num[63] ? 64'(-num) : 64'(num);
            den_reg <= den[63] ? 64'(-den) : 64'(den);
            rem_reg <= '0;
            neg_reg <= num[63] ^ den[63];
        end else if (busy_reg) begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[62:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

### rtl/aopu_cordic.sv
// ----------------------------------------------------------------------------
// aopu_cordic
// Sine and cosine of a binary angle, Q30, by a 30-step rotation CORDIC on
// the angle within its quadrant, one step per cycle.
// ----------------------------------------------------------------------------
module aopu_cordic (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic               done,
    output logic signed [33:0] sin_out,
    output logic signed [33:0] cos_out
);

    localparam logic [4:0] STEP_LAST = 5'(aopu_pkg::CORDIC_STEPS - 1);

    logic               busy_reg;
    logic               done_reg;
    logic [4:0]         i_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [32:0] z_reg;
    logic [1:0]         quad_reg;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [32:0] at;

    always_comb begin
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        at = $signed({3'b000, aopu_pkg::atan_bam(i_reg)});
        unique case (quad_reg)
            2'd0: begin
                cos_out = x_reg;
                sin_out = y_reg;
            end
            2'd1: begin
                cos_out = -y_reg;
                sin_out = x_reg;
            end
            2'd2: begin
                cos_out = -x_reg;
                sin_out = -y_reg;
            end
            default: begin
                cos_out = y_reg;
                sin_out = -x_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            done_reg <= busy_reg && (i_reg == STEP_LAST);
            if (start) begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
            end else if (busy_reg) begin
                i_reg <= i_reg + 5'd1;
                if (i_reg == STEP_LAST) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= aopu_pkg::CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= $signed({3'b000, angle[29:0]});
            quad_reg <= angle[31:30];
        end else if (busy_reg) begin
            if (!z_reg[32]) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign done = done_reg;

endmodule

### dv/tb_arc_odometry_pose_update.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_arc_odometry_pose_update
// Drives tick items through the pose update block under several wheel and
// gyro arrangements, predicts each pose result and compares it field by field.
// ----------------------------------------------------------------------------
module tb_arc_odometry_pose_update;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    aopu_pkg::in_item_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    aopu_pkg::out_item_t m_data;
    logic                cfg_we = 1'b0;
    logic [2:0]          cfg_index = '0;
    logic [31:0]         cfg_wdata = '0;

    bit                  calm = 1'b0;
    int                  errors = 0;
    int                  n_items = 0;
    int                  n_poses = 0;
    int                  n_status[3] = '{0, 0, 0};
    aopu_pkg::out_item_t pose_queue[$];

    // predictor state
    logic [1:0]         p_ng, p_nh, p_nv;
    logic signed [63:0] p_ho[2], p_vo[2];
    logic signed [63:0] p_x, p_y;
    logic [31:0]        p_hd;

    localparam logic signed [63:0] ATAN_TAB[30] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

    arc_odometry_pose_update dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #1 aclk = ~aclk;

    function automatic logic signed [63:0] q30_mul(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic [127:0] ua, ub, r;
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        r = (ua * ub + (128'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -$signed(r[63:0]) : $signed(r[63:0]);
    endfunction

    task automatic cordic(input logic [31:0] ang, output logic signed [63:0] s,
                          output logic signed [63:0] c);
        logic signed [63:0] x, y, z, xs, ys;
        x = 64'sd652032874;
        y = 0;
        z = {34'd0, ang[29:0]};
        for (int i = 0; i < 30; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - ATAN_TAB[i];
            end else begin
                x = x + ys; y = y - xs; z = z + ATAN_TAB[i];
            end
        end
        case (ang[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    function automatic logic signed [63:0] clamp_pos(logic signed [63:0] v);
        if (v > 64'sd140737488355327) return 64'sd140737488355327;
        if (v < -64'sd140737488355328) return -64'sd140737488355328;
        return v;
    endfunction

    function automatic logic signed [63:0] wheel_mean(logic [1:0] n,
            logic signed [63:0] d0, logic signed [63:0] d1, logic signed [63:0] o0,
            logic signed [63:0] o1, logic signed [63:0] chord,
            logic signed [63:0] two_s);
        logic signed [63:0] sum;
        sum = q30_mul(d0, chord) + q30_mul(o0, two_s);
        if (n == 0) return 0;
        if (n == 1) return sum;
        sum += q30_mul(d1, chord) + q30_mul(o1, two_s);
        return sum / 2;
    endfunction

    task automatic predict_pose(input aopu_pkg::in_item_t it);
        logic [1:0]          ng, nh, nv;
        logic signed [63:0]  g0, g1, hd0, hd1, vd0, vd1, num, den, delta, h;
        logic signed [63:0]  sh, ch, sm, cm, chord, lx, ly;
        aopu_pkg::status_t   st;
        aopu_pkg::out_item_t r;
        ng = p_ng > 2 ? 2'd2 : p_ng;
        nh = p_nh > 2 ? 2'd2 : p_nh;
        nv = p_nv > 2 ? 2'd2 : p_nv;
        g0 = it.gyro_delta_a; g1 = it.gyro_delta_b;
        hd0 = it.horiz_dist_a; hd1 = it.horiz_dist_b;
        vd0 = it.vert_dist_a; vd1 = it.vert_dist_b;
        st = aopu_pkg::STATUS_OK;
        delta = 0;
        if (ng > 0) begin
            delta = (ng > 1) ? (g0 + g1) / 2 : g0;
        end else if (nh == 2 || nv == 2) begin
            num = (nh == 2) ? hd0 - hd1 : vd0 - vd1;
            den = (nh == 2) ? p_ho[0] - p_ho[1] : p_vo[0] - p_vo[1];
            if (den == 0) begin
                st = aopu_pkg::STATUS_EQUAL_OFFSETS;
            end else begin
                delta = (num * 64'sd683565276) / den;
                if (delta > 64'sd2147483647) delta = 64'sd2147483647;
                if (delta < -64'sd2147483648) delta = -64'sd2147483648;
            end
        end else begin
            st = aopu_pkg::STATUS_NO_SOURCE;
        end
        if (st == aopu_pkg::STATUS_OK) begin
            h = delta / 2;
            if (h == 0) begin
                sh = 0;
                chord = 64'sd1 <<< 30;
            end else begin
                cordic(h[31:0], sh, ch);
                chord = (sh * 64'sd683565276) / h;
            end
            lx = wheel_mean(nh, hd0, hd1, p_ho[0], p_ho[1], chord, 2 * sh);
            ly = wheel_mean(nv, vd0, vd1, p_vo[0], p_vo[1], chord, 2 * sh);
            cordic(p_hd + h[31:0], sm, cm);
            p_x = clamp_pos(p_x + q30_mul(lx, cm) - q30_mul(ly, sm));
            p_y = clamp_pos(p_y + q30_mul(lx, sm) + q30_mul(ly, cm));
            p_hd = p_hd + delta[31:0];
        end
        r.position_x = p_x[47:0];
        r.position_y = p_y[47:0];
        r.heading_angle = p_hd;
        r.status_code = st;
        r.no_vertical = (p_nv == 0);
        n_status[st]++;
        pose_queue.push_back(r);
    endtask

    task automatic pause_random();
        if (!calm && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) @(posedge aclk);
    endtask

    task automatic send_tick(input aopu_pkg::in_item_t it);
        pause_random();
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_pose(it);
        n_items++;
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_reg(input aopu_pkg::cfg_index_t idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            aopu_pkg::CFG_GYRO_COUNT:     p_ng = val[1:0];
            aopu_pkg::CFG_HORIZ_COUNT:    p_nh = val[1:0];
            aopu_pkg::CFG_VERT_COUNT:     p_nv = val[1:0];
            aopu_pkg::CFG_HORIZ_OFFSET_A: p_ho[0] = $signed(val);
            aopu_pkg::CFG_HORIZ_OFFSET_B: p_ho[1] = $signed(val);
            aopu_pkg::CFG_VERT_OFFSET_A:  p_vo[0] = $signed(val);
            default:                      p_vo[1] = $signed(val);
        endcase
    endtask

    task automatic wait_idle();
        @(posedge aclk);
        while (pose_queue.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic set_layout(input logic [1:0] g, input logic [1:0] hc,
                              input logic [1:0] vc, input logic [31:0] ha,
                              input logic [31:0] hb, input logic [31:0] va,
                              input logic [31:0] vb);
        wait_idle();
        write_reg(aopu_pkg::CFG_GYRO_COUNT, {30'd0, g});
        write_reg(aopu_pkg::CFG_HORIZ_COUNT, {30'd0, hc});
        write_reg(aopu_pkg::CFG_VERT_COUNT, {30'd0, vc});
        write_reg(aopu_pkg::CFG_HORIZ_OFFSET_A, ha);
        write_reg(aopu_pkg::CFG_HORIZ_OFFSET_B, hb);
        write_reg(aopu_pkg::CFG_VERT_OFFSET_A, va);
        write_reg(aopu_pkg::CFG_VERT_OFFSET_B, vb);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
            3: return $urandom_range(0, 32'h1000) - 32'h800;
            default: return $urandom();
        endcase
    endfunction

    function automatic aopu_pkg::in_item_t rnd_tick();
        aopu_pkg::in_item_t it;
        it.gyro_delta_a = $urandom_range(0, 3) == 0 ? rnd_word() :
                          $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        it.gyro_delta_b = $urandom_range(0, 3) == 0 ? rnd_word() :
                          $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        it.horiz_dist_a = rnd_word();
        it.horiz_dist_b = rnd_word();
        it.vert_dist_a = rnd_word();
        it.vert_dist_b = rnd_word();
        return it;
    endfunction

    task automatic test_reset_layout();
        aopu_pkg::in_item_t it;
        // reset: two vertical wheels, equal (zero) offsets
        it = '0;
        send_tick(it);
        it = '1;
        send_tick(it);
    endtask

    task automatic test_directed();
        aopu_pkg::in_item_t it;
        set_layout(2'd0, 2'd0, 2'd0, 0, 0, 0, 0);
        send_tick(rnd_tick());
        set_layout(2'd2, 2'd2, 2'd2, 32'h0008_0000, 32'hFFF8_0000,
                   32'h0004_0000, 32'hFFFC_0000);
        it = '0;
        send_tick(it);
        it = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h8000_0000};
        send_tick(it);
        it = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF};
        send_tick(it);
        it = '{32'h1, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0};
        send_tick(it);
        it = '1;
        send_tick(it);
        set_layout(2'd1, 2'd1, 2'd3, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h8000_0000);
        for (int i = 0; i < 4; i++) send_tick(rnd_tick());
        set_layout(2'd3, 2'd3, 2'd1, 32'h0001_0000, 32'h0002_0000, 0, 0);
        for (int i = 0; i < 3; i++) send_tick(rnd_tick());
        // wheel heading from horizontal pair, then vertical pair, then equal
        set_layout(2'd0, 2'd2, 2'd2, 32'h0006_0000, 32'hFFFA_0000,
                   32'h0003_0000, 32'hFFFD_0000);
        for (int i = 0; i < 3; i++) send_tick(rnd_tick());
        set_layout(2'd0, 2'd1, 2'd2, 32'h0, 32'h0, 32'h0005_0000, 32'hFFFB_0000);
        for (int i = 0; i < 3; i++) send_tick(rnd_tick());
        set_layout(2'd0, 2'd2, 2'd0, 32'h0002_0000, 32'h0002_0000, 0, 0);
        send_tick(rnd_tick());
    endtask

    task automatic test_random();
        for (int blk = 0; blk < 22; blk++) begin
            set_layout(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                       2'($urandom_range(0, 3)), rnd_word(), rnd_word(),
                       rnd_word(), rnd_word());
            if (blk >= 19) calm = 1'b1;
            for (int i = 0; i < 24; i++) send_tick(rnd_tick());
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pose_queue.size() == 0) begin
                $display("%0t: unexpected result %p", $time, m_data);
                errors++;
            end else begin
                aopu_pkg::out_item_t e;
                e = pose_queue.pop_front();
                n_poses++;
                if (m_data.position_x !== e.position_x) begin
                    $display("%0t: position_x exp %h got %h", $time,
                             e.position_x, m_data.position_x);
                    errors++;
                end
                if (m_data.position_y !== e.position_y) begin
                    $display("%0t: position_y exp %h got %h", $time,
                             e.position_y, m_data.position_y);
                    errors++;
                end
                if (m_data.heading_angle !== e.heading_angle) begin
                    $display("%0t: heading_angle exp %h got %h", $time,
                             e.heading_angle, m_data.heading_angle);
                    errors++;
                end
                if (m_data.status_code !== e.status_code) begin
                    $display("%0t: status_code exp %0d got %0d", $time,
                             e.status_code, m_data.status_code);
                    errors++;
                end
                if (m_data.no_vertical !== e.no_vertical) begin
                    $display("%0t: no_vertical exp %0d got %0d", $time,
                             e.no_vertical, m_data.no_vertical);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (calm) m_ready <= 1'b1;
        else if (!m_ready) m_ready <= $urandom_range(0, 2) != 0;
        else m_ready <= $urandom_range(0, 4) != 0;
    end

    initial begin
        p_ng = 0; p_nh = 0; p_nv = 2;
        p_ho = '{0, 0}; p_vo = '{0, 0};
        p_x = 0; p_y = 0; p_hd = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_layout();
        test_directed();
        test_random();
        wait_idle();
        $display("%0d ticks sent, %0d poses checked (ok %0d, no source %0d, equal %0d)",
                 n_items, n_poses, n_status[0], n_status[1], n_status[2]);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
